@@ hw/rtl/mtr_pkg.sv @@
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types, constants and the color reduction for the mono-to-RGB565
// color expansion blitter.
// ----------------------------------------------------------------------------
package mtr_pkg;

  // Width for size arithmetic: covers any rectangle size up to 65535, plus one.
  localparam int SIZE_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORE_COLOR  = 3'd0,
    REG_BACK_COLOR  = 3'd1,
    REG_BACK_OPAQUE = 3'd2,
    REG_FIRST_BIT   = 3'd3,
    REG_RECT_WIDTH  = 3'd4,
    REG_RECT_HEIGHT = 3'd5
  } reg_idx_e;

  // One source byte as planned by the front end.
  typedef struct packed {
    logic [7:0] bits;      // source byte, leftmost pixel in bit 7
    logic [2:0] pos;       // bit position of the first pixel (0 = bit 7)
    logic [2:0] cnt_m1;    // pixel count minus one
    logic       row_last;  // the final pixel of this byte closes its row
    logic       rect_last; // the final pixel of this byte closes the rectangle
  } cmd_t;

  // RGB888 to 16-bit: red 23:19 -> 4:0, green 15:10 -> 10:5, blue 7:3 -> 15:11.
  function automatic logic [15:0] to_565(input logic [23:0] c);
    to_565 = {c[7:3], c[15:10], c[23:19]};
  endfunction

endpackage

@@ hw/rtl/mtr_fifo.sv @@
// ----------------------------------------------------------------------------
// mtr_fifo
// Two-entry queue between the byte planner and the pixel emitter.
// ----------------------------------------------------------------------------
module mtr_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

@@ hw/rtl/mtr_front.sv @@
// ----------------------------------------------------------------------------
// mtr_front
// Accepts source bytes, tracks column and row, and plans the pixel run of
// each byte for the emitter.
// ----------------------------------------------------------------------------
module mtr_front import mtr_pkg::*; #(
  parameter int MaxWidth  = 1024,
  parameter int MaxHeight = 1024,
  parameter int ColW      = 10,
  parameter int RowW      = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_ready_o,
  input  logic [2:0]      first_bit_i,
  input  logic [10:0]     rect_width_i,
  input  logic [10:0]     rect_height_i,
  input  logic            full_i,
  output logic            push_o,
  output cmd_t            cmd_o,
  output logic [ColW-1:0] col_o,
  output logic [RowW-1:0] row_o
);

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [SIZE_W-1:0] w, h, col_ext, row_ext, rem;
  logic [2:0]        pos;
  logic [3:0]        avail, n;
  logic              empty, row_done, last_row, accept;

  always_comb begin
    w = (SIZE_W'(rect_width_i) > SIZE_W'(MaxWidth)) ? SIZE_W'(MaxWidth)
                                                     : SIZE_W'(rect_width_i);
    h = (SIZE_W'(rect_height_i) > SIZE_W'(MaxHeight)) ? SIZE_W'(MaxHeight)
                                                       : SIZE_W'(rect_height_i);
    col_ext  = SIZE_W'(col_q);
    row_ext  = SIZE_W'(row_q);
    empty    = (w == '0) || (h == '0);
    // a row's first byte starts at the configured offset
    pos      = (col_q == '0) ? first_bit_i : 3'd0;
    avail    = 4'd8 - {1'b0, pos};
    // a counter at or past a shrunk size ends the row on the next pixel
    rem      = (col_ext + 1'b1 >= w) ? SIZE_W'(1) : w - col_ext;
    row_done = (rem <= SIZE_W'(avail));
    n        = row_done ? rem[3:0] : avail;
    last_row = (row_ext + 1'b1 >= h);
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && !empty;

  assign cmd_o.bits      = in_byte_i;
  assign cmd_o.pos       = pos;
  assign cmd_o.cnt_m1    = 3'(n - 4'd1);
  assign cmd_o.row_last  = row_done;
  assign cmd_o.rect_last = row_done && last_row;
  assign col_o           = col_q;
  assign row_o           = row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_done) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + ColW'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ hw/rtl/mtr_back.sv @@
// ----------------------------------------------------------------------------
// mtr_back
// Pops planned bytes and emits one colored pixel per cycle, while the sink
// accepts, into the output register.
// ----------------------------------------------------------------------------
module mtr_back import mtr_pkg::*; #(
  parameter int ColW = 10,
  parameter int RowW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  cmd_t            q_cmd_i,
  input  logic [ColW-1:0] q_col_i,
  input  logic [RowW-1:0] q_row_i,
  output logic            q_pop_o,
  input  logic [15:0]     fg_i,
  input  logic [15:0]     bg_i,
  input  logic            back_opaque_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     pixel_color_o,
  output logic            write_enable_o,
  output logic [9:0]      pixel_column_o,
  output logic [9:0]      pixel_row_o,
  output logic            row_end_o,
  output logic            byte_end_o,
  output logic            rect_end_o
);

  logic            act_q;
  cmd_t            cmd_q;
  logic [ColW-1:0] col_q, cur_col;
  logic [RowW-1:0] row_q;
  logic [2:0]      k_q, idx;
  logic            out_valid_q;
  logic            can_emit, last_px, pix;
  logic [ColW+9:0] col_wide;
  logic [RowW+9:0] row_wide;

  assign can_emit = act_q && (!out_valid_q || out_ready_i);
  assign last_px  = (k_q == cmd_q.cnt_m1);
  assign q_pop_o  = q_valid_i && (!act_q || (can_emit && last_px));
  assign idx      = cmd_q.pos + k_q;
  assign pix      = cmd_q.bits[~idx];
  assign cur_col  = col_q + ColW'(k_q);
  assign col_wide = {10'd0, cur_col};
  assign row_wide = {10'd0, row_q};
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        act_q <= 1'b1;
        k_q   <= '0;
      end else if (can_emit && last_px) begin
        act_q <= 1'b0;
        k_q   <= '0;
      end else if (can_emit) begin
        k_q <= k_q + 1'b1;
      end
      if (can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
      col_q <= q_col_i;
      row_q <= q_row_i;
    end
    if (can_emit) begin
      pixel_color_o  <= pix ? fg_i : bg_i;
      write_enable_o <= pix | back_opaque_i;
      pixel_column_o <= col_wide[9:0];
      pixel_row_o    <= row_wide[9:0];
      row_end_o      <= last_px && cmd_q.row_last;
      byte_end_o     <= last_px;
      rect_end_o     <= last_px && cmd_q.rect_last;
    end
  end

`ifndef SYNTHESIS
  a_rect_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rect_end_o) |-> row_end_o)
    else $error("rectangle end without row end");
  a_row_ends_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && row_end_o) |-> byte_end_o)
    else $error("row end before the end of its byte");
  a_run_in_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> ({1'b0, cmd_q.pos} + {1'b0, cmd_q.cnt_m1}) <= 4'd7)
    else $error("pixel run passes the end of the source byte");
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !can_emit) |-> !q_pop_o)
    else $error("byte popped while emitter busy");
`endif

endmodule

@@ hw/rtl/mono_to_rgb565_expand_blit.sv @@
// ----------------------------------------------------------------------------
// mono_to_rgb565_expand_blit
// Color expansion of a 1-bit source rectangle into 16-bit pixels.
// ----------------------------------------------------------------------------
// Each source byte (leftmost pixel in bit 7) expands into up to eight pixels,
// delivered one per cycle if the sink accepts, through one output register;
// a byte that starts at the first-bit offset or reaches the row end may yield
// fewer. The pixel emitter sets that rate. A planner in front tracks column
// and row, works out each byte's pixel run and hands it over a two-entry
// queue, so the next byte is taken while the current one is still being
// emitted and the stream runs at one pixel per cycle without gaps unless
// the source or sink stalls. While the width or height is zero, bytes are
// taken one per cycle and produce nothing. Write registers only while the
// block is idle; the block does not enforce it. Column and row counters are
// untouched by writes and wrap to zero after the last pixel of the rectangle.
module mono_to_rgb565_expand_blit import mtr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // source bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] source_byte
  // pixels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // [15:0] pixel_color, [25:16] pixel_column,
                                               // [35:26] pixel_row, [36] row_end,
                                               // [37] byte_end, [39:38] zero
  output logic                  m_axis_tuser,  // [0] write_enable
  output logic                  m_axis_tlast   // rect_end
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EntW  = $bits(cmd_t) + ColW + RowW;

  // configuration registers
  logic [23:0] fore_color_q, back_color_q;
  logic        back_opaque_q;
  logic [2:0]  first_bit_q;
  logic [10:0] rect_width_q, rect_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_color_q  <= 24'h000000;
      back_color_q  <= 24'hFFFFFF;
      back_opaque_q <= 1'b1;
      first_bit_q   <= 3'd0;
      rect_width_q  <= 11'd0;
      rect_height_q <= 11'd0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FORE_COLOR:  fore_color_q  <= cfg_data_i;
        REG_BACK_COLOR:  back_color_q  <= cfg_data_i;
        REG_BACK_OPAQUE: back_opaque_q <= cfg_data_i[0];
        REG_FIRST_BIT:   first_bit_q   <= cfg_data_i[2:0];
        REG_RECT_WIDTH:  rect_width_q  <= cfg_data_i[10:0];
        REG_RECT_HEIGHT: rect_height_q <= cfg_data_i[10:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // planner -> queue -> emitter
  logic            push, pop, full, q_valid;
  cmd_t            f_cmd, q_cmd;
  logic [ColW-1:0] f_col, q_col;
  logic [RowW-1:0] f_row, q_row;
  logic [EntW-1:0] q_rdata;

  mtr_front #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT),
    .ColW      (ColW),
    .RowW      (RowW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_byte_i     (s_axis_tdata),
    .in_ready_o    (s_axis_tready),
    .first_bit_i   (first_bit_q),
    .rect_width_i  (rect_width_q),
    .rect_height_i (rect_height_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (f_cmd),
    .col_o         (f_col),
    .row_o         (f_row)
  );

  mtr_fifo #(
    .Width (EntW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_cmd, f_col, f_row}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {q_cmd, q_col, q_row} = q_rdata;

  // emitter outputs
  logic [15:0] pixel_color;
  logic [9:0]  pixel_column, pixel_row;
  logic        write_enable, row_end, byte_end, rect_end;

  mtr_back #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_col_i        (q_col),
    .q_row_i        (q_row),
    .q_pop_o        (pop),
    .fg_i           (to_565(fore_color_q)),
    .bg_i           (to_565(back_color_q)),
    .back_opaque_i  (back_opaque_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_color_o  (pixel_color),
    .write_enable_o (write_enable),
    .pixel_column_o (pixel_column),
    .pixel_row_o    (pixel_row),
    .row_end_o      (row_end),
    .byte_end_o     (byte_end),
    .rect_end_o     (rect_end)
  );

  // pack the pixel transfer
  assign m_axis_tdata = {2'b00, byte_end, row_end, pixel_row, pixel_column, pixel_color};
  assign m_axis_tuser = write_enable;
  assign m_axis_tlast = rect_end;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mono-to-RGB565 expansion blitter. Source bytes
// go in on the slave stream. An in-bench predictor expands each accepted byte
// into its pixels. Each pixel transfer on the master stream is checked field
// by field against the oldest prediction. Directed cases come first, then
// random rectangles under several idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mtr_pkg::*;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned MAX_W        = 1024;
  localparam int unsigned MAX_H        = 1024;
  localparam int          SETTLE_CYCLES = 16;

  // One predicted pixel, with every field at its port width.
  typedef struct packed {
    logic [15:0] color;
    logic        wr_en;
    logic [9:0]  column;
    logic [9:0]  row;
    logic        row_end;
    logic        byte_end;
    logic        rect_end;
  } pixel_t;

  typedef struct packed {
    logic [4:0] blue;
    logic [5:0] green;
    logic [4:0] red;
  } rgb565_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] source_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;   // [15:0] color, [25:16] column, [35:26] row,
                                         // [36] row_end, [37] byte_end, [39:38] zero
  logic                  m_axis_tuser;   // [0] write_enable
  logic                  m_axis_tlast;   // rect_end

  // Predictor copy of the registers and the column/row position.
  logic [23:0] fg_rgb888;
  logic [23:0] bg_rgb888;
  logic        bg_opaque;
  logic [2:0]  start_bit;
  logic [10:0] rect_w;
  logic [10:0] rect_h;
  int unsigned cur_col;
  int unsigned cur_row;

  pixel_t expected_pixels[$];
  int     error_count;
  int     sender_idle_pct;
  int     receiver_stall_pct;

  mono_to_rgb565_expand_blit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pixel sink: drop tready at random according to the current stall rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [15:0] rgb888_to_565(input logic [23:0] c);
    rgb565_t p;
    p.red   = c[23:19];
    p.green = c[15:10];
    p.blue  = c[7:3];
    return p;
  endfunction

  // Expand one accepted source byte into the pixels it yields.
  task automatic expand_source_byte(input logic [7:0] src);
    int unsigned w;
    int unsigned h;
    int unsigned pos;
    logic        last_col;
    logic        last_row;
    pixel_t      px;
    // Saturate oversized rectangles.
    w = (rect_w > MAX_W) ? MAX_W : rect_w;
    h = (rect_h > MAX_H) ? MAX_H : rect_h;
    if (w == 0 || h == 0) return;
    // Only a row's first byte starts at the configured offset.
    pos = (cur_col == 0) ? start_bit : 0;
    while (pos < 8) begin
      // A counter at or past a shrunk size closes its row right away.
      last_col    = (cur_col + 1 >= w);
      last_row    = (cur_row + 1 >= h);
      px.color    = src[7 - pos] ? rgb888_to_565(fg_rgb888) : rgb888_to_565(bg_rgb888);
      px.wr_en    = src[7 - pos] ? 1'b1 : bg_opaque;
      px.column   = cur_col[9:0];
      px.row      = cur_row[9:0];
      px.row_end  = last_col;
      px.byte_end = last_col || (pos == 7);
      px.rect_end = last_col && last_row;
      expected_pixels.push_back(px);
      if (last_col) begin
        // Drop the rest of the byte; wrap after the rectangle's last pixel.
        cur_col = 0;
        cur_row = (last_col && last_row) ? 0 : cur_row + 1;
        pos     = 8;
      end else begin
        cur_col++;
        pos++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Track register writes and source transfers, and check every pixel transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_px;
    if (!rst_ni) begin
      fg_rgb888 = 24'h000000;
      bg_rgb888 = 24'hFFFFFF;
      bg_opaque = 1'b1;
      start_bit = 3'd0;
      rect_w    = 11'd0;
      rect_h    = 11'd0;
      cur_col   = 0;
      cur_row   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORE_COLOR:  fg_rgb888 = cfg_data_i;
          REG_BACK_COLOR:  bg_rgb888 = cfg_data_i;
          REG_BACK_OPAQUE: bg_opaque = cfg_data_i[0];
          REG_FIRST_BIT:   start_bit = cfg_data_i[2:0];
          REG_RECT_WIDTH:  rect_w    = cfg_data_i[10:0];
          REG_RECT_HEIGHT: rect_h    = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expand_source_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t ns: unexpected pixel, expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          error_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          check_field("pixel_color",  exp_px.color,             m_axis_tdata[15:0]);
          check_field("write_enable", 16'(exp_px.wr_en),       16'(m_axis_tuser));
          check_field("pixel_column", 16'(exp_px.column),      16'(m_axis_tdata[25:16]));
          check_field("pixel_row",    16'(exp_px.row),         16'(m_axis_tdata[35:26]));
          check_field("row_end",      16'(exp_px.row_end),     16'(m_axis_tdata[36]));
          check_field("byte_end",     16'(exp_px.byte_end),    16'(m_axis_tdata[37]));
          check_field("rect_end",     16'(exp_px.rect_end),    16'(m_axis_tlast));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Send one source byte; tvalid stays high afterwards so the next byte can
  // follow without a gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the source until every predicted pixel has gone out, then let the
  // block settle in case the last bytes produced nothing.
  task automatic wait_pixels_drained;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program the whole register set; call only while the block is drained.
  task automatic setup_blit(input logic [23:0] fg, input logic [23:0] bg,
                            input logic opaque, input logic [2:0] first,
                            input logic [10:0] w, input logic [10:0] h);
    write_reg(REG_FORE_COLOR,  fg);
    write_reg(REG_BACK_COLOR,  bg);
    write_reg(REG_BACK_OPAQUE, {23'd0, opaque});
    write_reg(REG_FIRST_BIT,   {21'd0, first});
    write_reg(REG_RECT_WIDTH,  {13'd0, w});
    write_reg(REG_RECT_HEIGHT, {13'd0, h});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Zero width (reset state) and zero height: bytes are taken, nothing comes out.
  task automatic test_empty_rect;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    wait_pixels_drained();
    setup_blit(24'h123456, 24'h654321, 1'b1, 3'd0, 11'd4, 11'd0);
    send_byte(8'h5A);
    send_byte(8'hC3);
    wait_pixels_drained();
  endtask

  // Full-scale colors and each channel mask on its own.
  task automatic test_color_extremes;
    setup_blit(24'hFFFFFF, 24'h000000, 1'b1, 3'd0, 11'd8, 11'd2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);
    wait_pixels_drained();
    setup_blit(24'hF80000, 24'h00FC00, 1'b1, 3'd0, 11'd8, 11'd2);
    send_byte(8'hAA);
    wait_pixels_drained();
    // Low channel bits must vanish in the reduction.
    setup_blit(24'h0000F8, 24'h070307, 1'b1, 3'd0, 11'd8, 11'd2);
    send_byte(8'h55);
    wait_pixels_drained();
  endtask

  // Clear bits keep the background color but are not written.
  task automatic test_transparent_background;
    setup_blit(24'h00FF00, 24'hFF00FF, 1'b0, 3'd0, 11'd16, 11'd1);
    send_byte(8'h0F);
    send_byte(8'hF0);
    wait_pixels_drained();
  endtask

  // Rows starting mid-byte: largest offset, then a middle one.
  task automatic test_first_bit_offset;
    setup_blit(24'hABCDEF, 24'h102030, 1'b1, 3'd7, 11'd10, 11'd2);
    repeat (4) send_byte(8'($urandom_range(255)));
    wait_pixels_drained();
    write_reg(REG_FIRST_BIT, 24'd3);
    send_byte(8'hB7);
    send_byte(8'h6D);
    wait_pixels_drained();
  endtask

  // Register values above the limits saturate to the maximum size.
  task automatic test_oversized_rect;
    setup_blit(24'h00FFFF, 24'hFFFF00, 1'b1, 3'd0, 11'h7FF, 11'h7FF);
    send_byte(8'h96);
    send_byte(8'h69);
    wait_pixels_drained();
  endtask

  // Shrink the rectangle mid-way, above the running counters: the next byte
  // closes its row and the rectangle, and the counters wrap.
  task automatic test_shrink_mid_rect;
    setup_blit(24'h808080, 24'h7F7F7F, 1'b1, 3'd0, 11'd30, 11'd3);
    send_byte(8'hE1);
    wait_pixels_drained();
    write_reg(REG_RECT_WIDTH,  24'd10);
    write_reg(REG_RECT_HEIGHT, 24'd1);
    send_byte(8'h3C);
    send_byte(8'hC3);
    wait_pixels_drained();
  endtask

  // Writes to indexes past the list must change nothing.
  task automatic test_spare_index;
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'hFFFFFF);
    send_byte(8'h81);
    wait_pixels_drained();
  endtask

  // Random rectangles, mostly small, under each idle/stall mix.
  task automatic test_random_rects;
    int idle_tab[4];
    int stall_tab[4];
    int sel;
    logic [10:0] w;
    logic [10:0] h;
    idle_tab  = '{0, 81, 0, 20};
    stall_tab = '{0, 0, 81, 20};
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_tab[ph];
      receiver_stall_pct = stall_tab[ph];
      for (int k = 0; k < 2; k++) begin
        sel = $urandom_range(9);
        if (sel == 0)      w = 11'd0;
        else if (sel == 1) w = 11'($urandom_range(1025, 2047));
        else               w = 11'($urandom_range(1, 24));
        sel = $urandom_range(9);
        if (sel == 0)      h = 11'd0;
        else if (sel == 1) h = 11'h7FF;
        else               h = 11'($urandom_range(1, 4));
        setup_blit(24'($urandom), 24'($urandom), 1'($urandom_range(1)),
                   3'($urandom_range(7)), w, h);
        repeat (8) send_byte(8'($urandom_range(255)));
        wait_pixels_drained();
      end
    end
  endtask

  // One full-width row so the last column and the rectangle end both appear,
  // then the counters wrap into the next rectangle.
  task automatic test_full_width_rows;
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    setup_blit(24'($urandom), 24'($urandom), 1'($urandom_range(1)),
               3'($urandom_range(7)), 11'd1024, 11'd1);
    repeat (130) send_byte(8'($urandom_range(255)));
    wait_pixels_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_FORE_COLOR;
    cfg_data_i         = '0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = 8'h00;
    error_count        = 0;
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_rect();
    test_color_extremes();
    test_transparent_background();
    test_first_bit_offset();
    test_oversized_rect();
    test_shrink_mid_rect();
    test_spare_index();
    test_random_rects();
    test_full_width_rows();

    if (error_count == 0) begin
      $display("PASS mono_to_rgb565_expand_blit");
    end else begin
      $display("FAIL mono_to_rgb565_expand_blit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL mono_to_rgb565_expand_blit");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mtr_pkg.sv
hw/rtl/mtr_fifo.sv
hw/rtl/mtr_front.sv
hw/rtl/mtr_back.sv
hw/rtl/mono_to_rgb565_expand_blit.sv
tb/sv/testbench.sv
